>>> design/rbs_pkg.sv
`default_nettype none

package rbs_pkg;

  // Store depth used when the top level is not overridden.
  localparam int MAX_RECORDS_DEF = 16;

  localparam int NAME_W = 160;

  // One stored record, laid out exactly as the stream word (age in the low bits).
  typedef struct packed {
    logic [31:0] last_lo;
    logic [63:0] last_mid;
    logic [63:0] last_hi;
    logic [31:0] first_lo;
    logic [63:0] first_mid;
    logic [63:0] first_hi;
    logic [31:0] salary;
    logic [7:0]  age;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_SORT  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KEY_AGE    = 2'd0,
    KEY_SALARY = 2'd1,
    KEY_FIRST  = 2'd2,
    KEY_LAST   = 2'd3
  } key_t;

endpackage

`default_nettype wire

>>> design/rbs_ram.sv
`default_nettype none

module rbs_ram #(
  parameter int WIDTH = rbs_pkg::REC_W,
  parameter int DEPTH = rbs_pkg::MAX_RECORDS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> design/rbs_cmp.sv
`default_nettype none

// Compare unit: high when record a must go after record b on the chosen key.
module rbs_cmp (
  input  wire rbs_pkg::rec_t a,
  input  wire rbs_pkg::rec_t b,
  input  wire rbs_pkg::key_t key,
  output logic               a_after_b
);

  // Zero every byte that follows the first zero byte; the masked strings then
  // order as plain big-endian numbers, which matches strcmp.
  function automatic logic [rbs_pkg::NAME_W-1:0] mask_name(
    input logic [rbs_pkg::NAME_W-1:0] s
  );
    logic [19:0]                 nz;
    logic [rbs_pkg::NAME_W-1:0]  m;
    logic                        keep;
    for (int k = 0; k < 20; k++) begin
      nz[k] = (s[rbs_pkg::NAME_W-1-8*k -: 8] != 8'd0);
    end
    for (int k = 0; k < 20; k++) begin
      keep = 1'b1;
      for (int j = 0; j < k; j++) begin
        keep = keep & nz[j];
      end
      m[rbs_pkg::NAME_W-1-8*k -: 8] = keep ? s[rbs_pkg::NAME_W-1-8*k -: 8] : 8'd0;
    end
    return m;
  endfunction

  logic [rbs_pkg::NAME_W-1:0] name_a;
  logic [rbs_pkg::NAME_W-1:0] name_b;

  always_comb begin
    unique case (key)
      rbs_pkg::KEY_FIRST: begin
        name_a = mask_name({a.first_hi, a.first_mid, a.first_lo});
        name_b = mask_name({b.first_hi, b.first_mid, b.first_lo});
      end
      default: begin
        name_a = mask_name({a.last_hi, a.last_mid, a.last_lo});
        name_b = mask_name({b.last_hi, b.last_mid, b.last_lo});
      end
    endcase
  end

  always_comb begin
    unique case (key)
      rbs_pkg::KEY_AGE:    a_after_b = (a.age > b.age);
      rbs_pkg::KEY_SALARY: a_after_b = ($signed(a.salary) > $signed(b.salary));
      default:             a_after_b = (name_a > name_b);
    endcase
  end

endmodule

`default_nettype wire

>>> design/record_bubble_sorter.sv
`default_nettype none

// Channel  Ports                                  Word contents (low bit up)
// -------  -------------------------------------  ---------------------------------
// input    in_tvalid in_tready in_tdata in_tuser  record; tuser = opcode
// output   out_tvalid out_tready out_tdata out_tlast  sorted record; tlast = last one
// config   cfg_wr_en cfg_wr_data                  sort key (0 age .. 3 last name)
//
// Load and clear words do not stall the input. A sort word over n records runs
// n - 1 compare-and-swap passes, each through S_PSTART, S_PRUN and S_PEND, bounded by the
// single RAM read port and the shared compare unit (one pair per cycle), then emits
// each record through S_ERD, S_ELD and S_EHOLD, where an output stall holds it.
// rst_n (synchronous) empties the store and sets the key to age; the record RAM
// is not cleared. in_tready stays low from a sort word until its last record is taken.
module record_bubble_sorter #(
  parameter int MAX_RECORDS = rbs_pkg::MAX_RECORDS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  // age, salary, first_hi, first_mid, first_lo, last_hi, last_mid, last_lo
  input  wire logic [rbs_pkg::REC_W-1:0] in_tdata,
  // opcode
  input  wire logic [1:0]                in_tuser,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  // age, salary, first_hi, first_mid, first_lo, last_hi, last_mid, last_lo
  output logic [rbs_pkg::REC_W-1:0]      out_tdata,
  output logic                           out_tlast,
  input  wire logic                      cfg_wr_en,
  input  wire logic [1:0]                cfg_wr_data
);

  localparam int AW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,  // take words
    S_PSTART = 7'b0000010,  // read the head of the pass
    S_PRUN   = 7'b0000100,  // one compare-and-swap per cycle
    S_PEND   = 7'b0001000,  // drop the carried record at the pass end
    S_ERD    = 7'b0010000,  // read the record to emit
    S_ELD    = 7'b0100000,  // load the output register
    S_EHOLD  = 7'b1000000   // hold until the word is taken
  } state_t;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;   // loaded records
  logic [CW-1:0]        len_r, len_nxt;       // records still in play this pass
  logic [AW-1:0]        dp_r, dp_nxt;         // address of the read data / emit index
  logic                 first_r, first_nxt;
  rbs_pkg::rec_t        carry_r, carry_nxt;   // record bubbling up the pass
  rbs_pkg::key_t        key_r, key_nxt;
  rbs_pkg::rec_t        out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [rbs_pkg::REC_W-1:0] ram_wdata, ram_rdata;
  rbs_pkg::rec_t        rd_rec;
  logic                 carry_after;
  logic [CW-1:0]        dp_inc;
  logic [CW-1:0]        len_dec;

  assign rd_rec  = rbs_pkg::rec_t'(ram_rdata);
  assign dp_inc  = CW'(dp_r) + CW'(1);
  assign len_dec = len_r - CW'(1);

  rbs_ram #(
    .WIDTH (rbs_pkg::REC_W),
    .DEPTH (MAX_RECORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rbs_cmp u_cmp (
    .a         (carry_r),
    .b         (rd_rec),
    .key       (key_r),
    .a_after_b (carry_after)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    len_nxt       = len_r;
    dp_nxt        = dp_r;
    first_nxt     = first_r;
    carry_nxt     = carry_r;
    key_nxt       = cfg_wr_en ? rbs_pkg::key_t'(cfg_wr_data) : key_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_waddr     = dp_r;
    ram_wdata     = carry_r;
    ram_re        = 1'b0;
    ram_raddr     = dp_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          unique case (in_tuser)
            rbs_pkg::OP_LOAD: begin
              // Append; drop the word when the store is full.
              if (count_r < CW'(MAX_RECORDS)) begin
                ram_we    = 1'b1;
                ram_waddr = count_r[AW-1:0];
                ram_wdata = in_tdata;
                count_nxt = count_r + CW'(1);
              end
            end
            rbs_pkg::OP_SORT: begin
              dp_nxt = '0;
              if (count_r >= CW'(2)) begin
                len_nxt   = count_r;
                state_nxt = S_PSTART;
              end else if (count_r == CW'(1)) begin
                state_nxt = S_ERD;
              end
            end
            rbs_pkg::OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_PSTART: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        dp_nxt    = '0;
        first_nxt = 1'b1;
        state_nxt = S_PRUN;
      end

      S_PRUN: begin
        // Read data is entry dp_r; the carried record sits logically at dp_r - 1.
        if (first_r) begin
          carry_nxt = rd_rec;
          first_nxt = 1'b0;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = dp_r - AW'(1);
          if (carry_after) begin
            ram_wdata = ram_rdata;
          end else begin
            ram_wdata = carry_r;
            carry_nxt = rd_rec;
          end
        end
        if (dp_inc < len_r) begin
          ram_re    = 1'b1;
          ram_raddr = dp_inc[AW-1:0];
          dp_nxt    = dp_inc[AW-1:0];
        end else begin
          state_nxt = S_PEND;
        end
      end

      S_PEND: begin
        // The largest record of the pass lands at its final place.
        ram_we    = 1'b1;
        ram_waddr = len_dec[AW-1:0];
        ram_wdata = carry_r;
        len_nxt   = len_dec;
        dp_nxt    = '0;
        if (len_dec >= CW'(2)) begin
          state_nxt = S_PSTART;
        end else begin
          state_nxt = S_ERD;
        end
      end

      S_ERD: begin
        ram_re    = 1'b1;
        ram_raddr = dp_r;
        state_nxt = S_ELD;
      end

      S_ELD: begin
        out_nxt       = rd_rec;
        out_valid_nxt = 1'b1;
        out_last_nxt  = (dp_inc == count_r);
        state_nxt     = S_EHOLD;
      end

      S_EHOLD: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            dp_nxt    = dp_inc[AW-1:0];
            state_nxt = S_ERD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      len_r       <= '0;
      dp_r        <= '0;
      first_r     <= 1'b0;
      key_r       <= rbs_pkg::KEY_AGE;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      len_r       <= len_nxt;
      dp_r        <= dp_nxt;
      first_r     <= first_nxt;
      key_r       <= key_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    carry_r <= carry_nxt;
    out_r   <= out_nxt;
  end

endmodule

`default_nettype wire

>>> design/rbs_checker.sv
`default_nettype none

module rbs_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_tvalid,
  input wire logic                      in_tready,
  input wire logic [1:0]                in_tuser,
  input wire logic                      out_tvalid,
  input wire logic                      out_tready,
  input wire logic [rbs_pkg::REC_W-1:0] out_tdata,
  input wire logic                      out_tlast
);

  // Reset leaves the block ready with nothing to send.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (in_tready && !out_tvalid))
    else $error("not idle after reset");

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("output word changed under stall");

  // No input is taken while a sorted run is being sent.
  a_busy_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("ready while emitting");

  // Load and clear words leave the input ready in the following cycle.
  a_quick_ops: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready &&
     (in_tuser == rbs_pkg::OP_LOAD || in_tuser == rbs_pkg::OP_CLEAR)) |=> in_tready)
    else $error("load or clear stalled the input");

  // The last word of a run ends emission.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> !out_tvalid)
    else $error("word after the last of a run");

endmodule

bind record_bubble_sorter rbs_checker u_rbs_checker (.*);

`default_nettype wire
